// File: design/swm_pkg.sv
package swm_pkg;

    localparam int MAX_WINDOW_DEF = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int SAMPLE_W       = 32;
    localparam int WSIZE_W        = 11;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_READ,
        ST_EMIT,
        ST_DROP
    } state_t;

endpackage

// File: design/swm_front.sv
module swm_front #(
    parameter int DW = swm_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [swm_pkg::SAMPLE_W-1:0] sample,
    output logic                        q_valid,
    input  logic                        q_pop,
    output logic [DW-1:0]               q_data
);

    // Two-entry queue of masked samples between the ports and the back end.
    logic [DW-1:0] mem_reg [2];
    logic          wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Payload storage; sample is truncated to the data width.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= DW'(sample);
    end

endmodule

// File: design/swm_back.sv
module swm_back #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
    parameter int DW         = swm_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [swm_pkg::WSIZE_W-1:0]  cfg_wdata,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  logic [DW-1:0]                q_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [swm_pkg::SAMPLE_W-1:0] window_min
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int WW = (CW > swm_pkg::WSIZE_W) ? CW : swm_pkg::WSIZE_W;

    // Each stack entry holds the value and the running minimum.
    logic [2*DW-1:0] newer_mem [MAX_WINDOW];
    logic [2*DW-1:0] older_mem [MAX_WINDOW];
    logic [2*DW-1:0] n_rd_reg, o_rd_reg;
    logic            n_re, o_re, n_we, o_we;
    logic [AW-1:0]   n_ra, o_ra, n_wa, o_wa;
    logic [2*DW-1:0] n_wd, o_wd;

    swm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   ncnt_reg, ncnt_next, ocnt_reg, ocnt_next, fill_reg, fill_next;
    logic [CW-1:0]   wsize_reg;
    logic [DW-1:0]   samp_reg, samp_next, res_reg, res_next;
    logic            ov_reg, ov_next;
    logic [WW-1:0]   wclip;
    logic [DW-1:0]   n_top, o_top, n_val, wmin;

    assign n_top = n_rd_reg[DW-1:0];
    assign n_val = n_rd_reg[2*DW-1:DW];
    assign o_top = o_rd_reg[DW-1:0];

    // Window size saturated into 1..MAX_WINDOW.
    always_comb
    begin
        wclip = WW'(cfg_wdata);
        if (wclip == '0)
            wclip = WW'(1);
        else if (wclip > WW'(MAX_WINDOW))
            wclip = WW'(MAX_WINDOW);
    end

    // Minimum over both stack tops.
    always_comb
    begin
        if (ncnt_reg == '0 && ocnt_reg == '0)
            wmin = '0;
        else if (ncnt_reg == '0)
            wmin = o_top;
        else if (ocnt_reg == '0)
            wmin = n_top;
        else
            wmin = (n_top < o_top) ? n_top : o_top;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
                if (q_valid && !cfg_we)
                    state_next = swm_pkg::ST_PUSH;
            swm_pkg::ST_PUSH:
                if (fill_reg + CW'(1) >= wsize_reg)
                    state_next = (ocnt_reg == '0) ?
                                 swm_pkg::ST_MOVE_RD : swm_pkg::ST_READ;
                else
                    state_next = swm_pkg::ST_IDLE;
            swm_pkg::ST_MOVE_RD:
                state_next = swm_pkg::ST_MOVE_WR;
            swm_pkg::ST_MOVE_WR:
                state_next = (ncnt_reg == CW'(1)) ? swm_pkg::ST_READ : swm_pkg::ST_MOVE_RD;
            swm_pkg::ST_READ:
                state_next = swm_pkg::ST_EMIT;
            swm_pkg::ST_EMIT:
                if (!ov_reg)
                    state_next = swm_pkg::ST_DROP;
            swm_pkg::ST_DROP:
                state_next = swm_pkg::ST_IDLE;
            default:
                state_next = swm_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        ncnt_next = ncnt_reg;
        ocnt_next = ocnt_reg;
        fill_next = fill_reg;
        samp_next = samp_reg;
        res_next  = res_reg;
        ov_next   = ov_reg && out_stall;
        q_pop = 1'b0;
        n_re = 1'b0; o_re = 1'b0; n_we = 1'b0; o_we = 1'b0;
        n_ra = AW'(ncnt_reg - CW'(1));
        o_ra = AW'(ocnt_reg - CW'(1));
        n_wa = AW'(ncnt_reg);
        o_wa = AW'(ocnt_reg);
        n_wd = '0; o_wd = '0;
        unique case (state_reg)
            swm_pkg::ST_IDLE:
                if (q_valid && !cfg_we)
                begin
                    q_pop     = 1'b1;
                    samp_next = q_data;
                    n_re      = (ncnt_reg != '0);
                end
            swm_pkg::ST_PUSH:
            begin
                n_we = 1'b1;
                n_wd = {samp_reg, ((ncnt_reg != '0) && n_top < samp_reg) ? n_top : samp_reg};
                ncnt_next = ncnt_reg + CW'(1);
                fill_next = fill_reg + CW'(1);
            end
            swm_pkg::ST_MOVE_RD:
                n_re = 1'b1;
            swm_pkg::ST_MOVE_WR:
            begin
                // Older top is the previous write, still held in o_rd_reg via bypass.
                o_we = 1'b1;
                o_wd = {n_val, ((ocnt_reg != '0) && o_top < n_val) ? o_top : n_val};
                ncnt_next = ncnt_reg - CW'(1);
                ocnt_next = ocnt_reg + CW'(1);
            end
            swm_pkg::ST_READ:
            begin
                n_re = (ncnt_reg != '0);
                o_re = (ocnt_reg != '0);
            end
            swm_pkg::ST_EMIT:
                if (!ov_reg)
                begin
                    ov_next  = 1'b1;
                    res_next = wmin;
                end
            swm_pkg::ST_DROP:
            begin
                if (ocnt_reg != '0)
                    ocnt_next = ocnt_reg - CW'(1);
                fill_next = fill_reg - CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swm_pkg::ST_IDLE;
            ncnt_reg  <= '0;
            ocnt_reg  <= '0;
            fill_reg  <= '0;
            wsize_reg <= CW'(1);
            ov_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            state_reg <= swm_pkg::ST_IDLE;
            ncnt_reg  <= '0;
            ocnt_reg  <= '0;
            fill_reg  <= '0;
            wsize_reg <= CW'(wclip);
            ov_reg    <= ov_reg && out_stall;
        end
        else
        begin
            state_reg <= state_next;
            ncnt_reg  <= ncnt_next;
            ocnt_reg  <= ocnt_next;
            fill_reg  <= fill_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        res_reg  <= res_next;
    end

    // Newer stack memory.
    always_ff @(posedge clk)
    begin
        if (n_we)
            newer_mem[n_wa] <= n_wd;
        if (n_re)
            n_rd_reg <= newer_mem[n_ra];
    end

    // Older stack memory; a write forwards into the read register so the
    // running minimum of the new top is at hand for the next transfer step.
    always_ff @(posedge clk)
    begin
        if (o_we)
            older_mem[o_wa] <= o_wd;
        if (o_we)
            o_rd_reg <= o_wd;
        else if (o_re)
            o_rd_reg <= older_mem[o_ra];
    end

    assign out_valid  = ov_reg;
    assign window_min = swm_pkg::SAMPLE_W'(res_reg);

endmodule

// File: design/sliding_window_minimum_unit.sv
// Sliding-window minimum over the last window_size samples (1 to MAX_WINDOW),
// built as a queue of two stacks held in single-port-style memories. A two-entry
// input queue takes requests while the back end works. A sample that does not
// complete the window is only pushed; one that yields a result also reads both
// stack tops, emits the minimum and drops the oldest entry, first reversing the
// newer stack into an empty older one by a read then write per entry. Writing
// window_size empties the window; no new result is made until it has refilled.
module sliding_window_minimum_unit #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF,
    parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [swm_pkg::WSIZE_W-1:0]  cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [swm_pkg::SAMPLE_W-1:0] sample,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [swm_pkg::SAMPLE_W-1:0] window_min
);

    logic                  q_valid, q_pop;
    logic [DATA_WIDTH-1:0] q_data;

    swm_front #(.DW(DATA_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
    );

    swm_back #(.MAX_WINDOW(MAX_WINDOW), .DW(DATA_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
        .out_valid(out_valid), .out_stall(out_stall), .window_min(window_min)
    );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SAMPLE_W = swm_pkg::SAMPLE_W;
    localparam int WSIZE_W  = swm_pkg::WSIZE_W;
    localparam int MAXW = swm_pkg::MAX_WINDOW_DEF;
    localparam int BIG_WIN = 200;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [WSIZE_W-1:0]  cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample;
    logic                out_valid;
    logic                out_stall;
    logic [SAMPLE_W-1:0] window_min;

    sliding_window_minimum_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .window_min (window_min)
    );

    // Predictor state: the samples currently in the window, oldest first.
    logic [SAMPLE_W-1:0] window_q[$];
    int                  win_len;
    logic [SAMPLE_W-1:0] min_q[$];

    int  errors;
    int  table_errors;
    int  requests_sent;
    int  results_seen;
    int  idle_cycles;
    bit  hold_off;
    bit  long_hold_req;
    bit  sender_paused;
    bit  finished;

    // Directed table: sample value and, where obvious, the expected minimum.
    typedef struct {
        logic [SAMPLE_W-1:0] value;
        bit                  has_exp;
        logic [SAMPLE_W-1:0] exp_min;
    } dir_row_t;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Apply a window-size write to the predictor.
    function automatic void predict_config(input logic [WSIZE_W-1:0] w);
        int n;
        n = int'(w);
        if (n == 0)
            n = 1;
        if (n > MAXW)
            n = MAXW;
        win_len = n;
        window_q.delete();
    endfunction

    // Push one sample; return 1 with the window minimum once the window is full.
    function automatic bit predict_minimum(input logic [SAMPLE_W-1:0] s,
                                           output logic [SAMPLE_W-1:0] m);
        window_q.push_back(s);
        if (window_q.size() < win_len)
            return 1'b0;
        m = window_q[0];
        foreach (window_q[i])
            if (window_q[i] < m)
                m = window_q[i];
        void'(window_q.pop_front());
        return 1'b1;
    endfunction

    // Result checker and acceptance watchdog.
    always @(posedge clk)
    begin
        logic [SAMPLE_W-1:0] exp_v;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (min_q.size() == 0)
                begin
                    $error("window_min: unexpected result %h", window_min);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_v = min_q.pop_front();
                    if (exp_v !== window_min)
                    begin
                        $error("window_min: expected %h, got %h", exp_v, window_min);
                        errors <= errors + 1;
                    end
                end
            end
            if (idle_cycles > WATCHDOG_LIMIT && !finished)
            begin
                $display("Watchdog expired with %0d results outstanding", min_q.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request.
    initial
    begin
        int cnt;
        out_stall = 1'b0;
        cnt = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                cnt = cnt + 1;
                if (cnt > 300)
                begin
                    long_hold_req = 1'b0;
                    cnt = 0;
                end
            end
            else if (hold_off)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= 1'b0;
        end
    end

    // Offer one sample and wait until it is taken; record its expectation.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit has_exp,
                               input logic [SAMPLE_W-1:0] exp_fixed);
        logic [SAMPLE_W-1:0] m;
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        if (predict_minimum(s, m))
        begin
            if (has_exp && m !== exp_fixed)
            begin
                $error("window_min: table expects %h, predictor %h", exp_fixed, m);
                table_errors++;
            end
            min_q.push_back(m);
        end
    endtask

    task automatic drain_and_configure(input logic [WSIZE_W-1:0] w);
        in_valid <= 1'b0;
        while (min_q.size() != 0)
            @(posedge clk);
        // Samples that do not fill the window may still be in flight.
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        predict_config(w);
    endtask

    // Random burst sender with gaps between bursts.
    task automatic random_samples(input int count, input int maxval);
        int burst;
        int gap;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                gap = $urandom_range(0, 4);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 12);
            end
            burst--;
            if ($urandom_range(0, 3) == 0)
                send_sample($urandom, 1'b0, '0);
            else
                send_sample($urandom_range(0, maxval), 1'b0, '0);
        end
    endtask

    initial
    begin
        dir_row_t dir_rows[$];
        int       sizes[$];
        errors = 0;
        table_errors = 0;
        requests_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        long_hold_req = 1'b0;
        finished = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        sample = '0;
        predict_config(1);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the window is one sample wide: each result is the sample.
        dir_rows.push_back('{32'h0000_0000, 1'b1, 32'h0000_0000});
        dir_rows.push_back('{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF});
        dir_rows.push_back('{32'h8000_0000, 1'b1, 32'h8000_0000});
        dir_rows.push_back('{32'h0000_0001, 1'b1, 32'h0000_0001});
        dir_rows.push_back('{32'h5555_5555, 1'b1, 32'h5555_5555});
        dir_rows.push_back('{32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA});
        foreach (dir_rows[i])
            send_sample(dir_rows[i].value, dir_rows[i].has_exp, dir_rows[i].exp_min);

        // Window of three over a descending then ascending run.
        drain_and_configure(3);
        dir_rows.delete();
        dir_rows.push_back('{32'hFFFF_FFFF, 1'b0, '0});
        dir_rows.push_back('{32'h7000_0000, 1'b0, '0});
        dir_rows.push_back('{32'h0000_0005, 1'b0, '0});
        dir_rows.push_back('{32'h0000_0009, 1'b0, '0});
        dir_rows.push_back('{32'hFFFF_FFFE, 1'b0, '0});
        dir_rows.push_back('{32'hFFFF_FFFF, 1'b0, '0});
        dir_rows.push_back('{32'h0000_0000, 1'b0, '0});
        foreach (dir_rows[i])
            send_sample(dir_rows[i].value, 1'b0, '0);

        // Size zero behaves as one; size above the limit saturates.
        drain_and_configure(0);
        send_sample(32'h1234_5678, 1'b1, 32'h1234_5678);
        send_sample(32'h0000_00FF, 1'b1, 32'h0000_00FF);
        drain_and_configure(11'h7FF);
        random_samples(20, 1000);
        // Window is emptied by a rewrite before it fills; no result expected.

        // Random phases over several window sizes, a long window among them.
        sizes = {2, 5, 1, 17, 4, BIG_WIN, 64};
        foreach (sizes[k])
        begin
            drain_and_configure(sizes[k]);
            hold_off = (k % 2 == 1);
            if (k == 1)
                long_hold_req = 1'b1;
            random_samples(sizes[k] == BIG_WIN ? BIG_WIN + 40 : 50, 255);
        end
        hold_off = 1'b1;
        drain_and_configure(2);
        random_samples(60, 65535);

        in_valid <= 1'b0;
        while (min_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        finished = 1'b1;
        $display("Sent %0d samples and checked %0d window minima", requests_sent,
                 results_seen);
        $display("Window sizes covered: 0, 1, 2, 3, 4, 5, 17, 64, 200 and saturation to 1024");
        if (errors == 0 && table_errors == 0 && min_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
design/swm_pkg.sv
design/swm_front.sv
design/swm_back.sv
design/sliding_window_minimum_unit.sv
dv/tb.sv
